// ----- rtl/core/wav_pkg.sv -----
// shared types and constants for the wav riff header parser
// no dependencies
package wav_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_CHUNK,
      PH_FMT,
      PH_SKIP,
      PH_DIV,
      PH_OUT
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_MAGIC = 3'd1,
      ST_BAD_TAG   = 3'd2,
      ST_MISSING   = 3'd3,
      ST_ZERO_ALIGN = 3'd4,
      ST_ZERO_FRAMES = 3'd5
   } status_type;

   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [15:0] FMT_PCM = 16'h0001;
   localparam logic [15:0] FMT_EXT = 16'hFFFE;
   localparam logic [31:0] FMT_MIN = 32'd16;
   localparam int          DIV_STEPS = 32;

   // controller -> datapath
   typedef struct packed {
      logic       clear;      // restart on first byte
      logic       advance;    // count a non-first byte
      logic       hdr_byte;
      logic       chunk_byte;
      logic       fmt_byte;
      logic       skip_byte;
      logic       load_skip;  // load skip count from chunk length
      logic       fmt_skip;   // skip count minus the decoded 16 bytes
      logic       start_chunk;
      logic       div_start;
      logic       div_step;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       magic_bad_now;
      logic       sect_hdr_end;
      logic       sect_chunk_end;
      logic       sect_fmt_end;
      logic       is_fmt;
      logic       is_data;
      logic       tag_ok;
      logic       have_fmt;
      logic       skip_zero_next;
      logic       align_zero;
      logic       div_done;
      logic       frames_zero;
   } stat_type;

endpackage

// ----- rtl/core/wav_datapath.sv -----
// datapath: header byte gathering, fmt fields, skip counter and frame divider
// depends on wav_pkg
module wav_datapath (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [31:0]     csr_wdata,
   input  logic [7:0]      data_byte,
   input  wav_pkg::cmd_type cmd,
   output wav_pkg::stat_type stat,
   output logic [15:0]     o_channels,
   output logic [31:0]     o_rate,
   output logic [15:0]     o_align,
   output logic [15:0]     o_bits,
   output logic [31:0]     o_offset,
   output logic [31:0]     o_bytes,
   output logic [31:0]     o_frames,
   output logic            o_playable
);
   import wav_pkg::*;

   logic [31:0] fsize_ff;
   logic [31:0] pos_ff, pos_in;
   logic [3:0]  sect_ff, sect_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] skip_ff, skip_in;
   logic        magic_ff, magic_in;
   logic        have_ff, have_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] al_ff, al_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] dalign_ff, dalign_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [3:0]  c;
   logic [7:0]  tag_byte;
   logic [32:0] skip_base;
   logic [32:0] skip_chunk;
   logic [31:0] offset;
   logic [31:0] avail;
   logic [15:0] der_align;
   logic [32:0] trial;
   logic [31:0] new_id;
   logic [31:0] new_len;

   // a first byte always counts as header byte zero
   assign c = cmd.clear ? 4'd0 : sect_ff;
   // data starts right after the header beat being taken now
   assign offset = pos_ff + 32'd2;
   assign avail = fsize_ff - offset;
   assign der_align = (al_ff != 16'd0) ? al_ff : 16'(ch_ff * {3'd0, bits_ff[15:3]});
   assign trial = {rem_ff, bytes_ff[31]} - {17'd0, dalign_ff};
   assign skip_base = {1'b0, len_ff} + {32'd0, len_ff[0]};

   always_comb begin
      case (c[1:0])
         2'd0:    tag_byte = (c[3]) ? TAG_WAVE[7:0]   : TAG_RIFF[7:0];
         2'd1:    tag_byte = (c[3]) ? TAG_WAVE[15:8]  : TAG_RIFF[15:8];
         2'd2:    tag_byte = (c[3]) ? TAG_WAVE[23:16] : TAG_RIFF[23:16];
         default: tag_byte = (c[3]) ? TAG_WAVE[31:24] : TAG_RIFF[31:24];
      endcase
   end

   always_comb begin
      new_id = id_ff;
      new_len = len_ff;
      case (c[2:0])
         3'd0: new_id[7:0]   = data_byte;
         3'd1: new_id[15:8]  = data_byte;
         3'd2: new_id[23:16] = data_byte;
         3'd3: new_id[31:24] = data_byte;
         3'd4: new_len[7:0]   = data_byte;
         3'd5: new_len[15:8]  = data_byte;
         3'd6: new_len[23:16] = data_byte;
         default: new_len[31:24] = data_byte;
      endcase
   end

   // skip length of a chunk whose size completes on this beat
   assign skip_chunk = {1'b0, new_len} + {32'd0, new_len[0]};

   always_comb begin
      pos_in = pos_ff;  sect_in = sect_ff;  id_in = id_ff;  len_in = len_ff;
      skip_in = skip_ff; magic_in = magic_ff; have_in = have_ff; tag_in = tag_ff;
      ch_in = ch_ff; rate_in = rate_ff; al_in = al_ff; bits_in = bits_ff;
      dalign_in = dalign_ff; bytes_in = bytes_ff; quo_in = quo_ff;
      rem_in = rem_ff; cnt_in = cnt_ff;
      if (cmd.clear) begin
         pos_in = '0; sect_in = '0; id_in = '0; len_in = '0; skip_in = '0;
         magic_in = 1'b0; have_in = 1'b0; tag_in = '0; ch_in = '0;
         rate_in = '0; al_in = '0; bits_in = '0;
      end
      if (cmd.advance) pos_in = pos_ff + 32'd1;
      if (cmd.hdr_byte) begin
         if ((c < 4'd4 || c >= 4'd8) && data_byte != tag_byte) magic_in = 1'b1;
         sect_in = c + 4'd1;
      end
      if (cmd.chunk_byte) begin
         id_in = new_id;
         len_in = new_len;
         sect_in = {1'b0, c[2:0] + 3'd1};
      end
      if (cmd.fmt_byte) begin
         case (c)
            4'd0:  tag_in[7:0]     = data_byte;
            4'd1:  tag_in[15:8]    = data_byte;
            4'd2:  ch_in[7:0]      = data_byte;
            4'd3:  ch_in[15:8]     = data_byte;
            4'd4:  rate_in[7:0]    = data_byte;
            4'd5:  rate_in[15:8]   = data_byte;
            4'd6:  rate_in[23:16]  = data_byte;
            4'd7:  rate_in[31:24]  = data_byte;
            4'd12: al_in[7:0]      = data_byte;
            4'd13: al_in[15:8]     = data_byte;
            4'd14: bits_in[7:0]    = data_byte;
            4'd15: bits_in[15:8]   = data_byte;
            default: ;
         endcase
         sect_in = c + 4'd1;
         if (c == 4'd15) have_in = 1'b1;
      end
      if (cmd.load_skip) begin
         skip_in = skip_chunk;
         sect_in = '0;
      end
      if (cmd.fmt_skip) skip_in = skip_base - 33'd16;
      if (cmd.skip_byte && skip_ff != 33'd0) skip_in = skip_ff - 33'd1;
      if (cmd.start_chunk) begin
         sect_in = '0; id_in = '0; len_in = '0;
      end
      if (cmd.div_start) begin
         dalign_in = der_align;
         bytes_in = new_len;
         if (fsize_ff != 32'd0 && offset < fsize_ff && new_len > avail) bytes_in = avail;
         quo_in = '0;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         // restoring division, one quotient bit per cycle, dividend shifts in msb first
         bytes_in = {bytes_ff[30:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], bytes_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsize_ff <= '0;
         pos_ff <= '0; sect_ff <= '0; id_ff <= '0; len_ff <= '0; skip_ff <= '0;
         magic_ff <= 1'b0; have_ff <= 1'b0; tag_ff <= '0; ch_ff <= '0;
         rate_ff <= '0; al_ff <= '0; bits_ff <= '0; cnt_ff <= '0;
      end else begin
         if (csr_we) fsize_ff <= csr_wdata;
         pos_ff <= pos_in; sect_ff <= sect_in; id_ff <= id_in; len_ff <= len_in;
         skip_ff <= skip_in; magic_ff <= magic_in; have_ff <= have_in;
         tag_ff <= tag_in; ch_ff <= ch_in; rate_ff <= rate_in; al_ff <= al_in;
         bits_ff <= bits_in; cnt_ff <= cnt_in;
      end
   end

   // divider operands need no reset
   logic [31:0] bytes_keep_ff;
   always_ff @(posedge clock) begin
      dalign_ff <= dalign_in;
      bytes_ff <= bytes_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.div_start) bytes_keep_ff <= bytes_in;
   end

   assign stat.magic_bad_now  = magic_in;
   assign stat.sect_hdr_end   = (c == 4'd11);
   assign stat.sect_chunk_end = (c[2:0] == 3'd7);
   assign stat.sect_fmt_end   = (c == 4'd15);
   assign stat.is_fmt         = (new_id == ID_FMT) && (new_len >= FMT_MIN);
   assign stat.is_data        = (new_id == ID_DATA);
   assign stat.tag_ok         = (tag_in == FMT_PCM) || (tag_in == FMT_EXT);
   assign stat.have_fmt       = have_ff;
   assign stat.skip_zero_next = (skip_in == 33'd0);
   assign stat.align_zero     = (der_align == 16'd0);
   assign stat.div_done       = (cnt_ff == 6'(DIV_STEPS));
   assign stat.frames_zero    = (quo_ff == 32'd0);

   assign o_channels = ch_ff;
   assign o_rate     = rate_ff;
   assign o_align    = dalign_ff;
   assign o_bits     = bits_ff;
   assign o_offset   = pos_ff + 32'd1;
   assign o_bytes    = bytes_keep_ff;
   assign o_frames   = quo_ff;
   assign o_playable = (bits_ff == 16'd16) && (ch_ff >= 16'd1) && (ch_ff <= 16'd8)
                       && ({1'b0, dalign_ff} == {ch_ff, 1'b0});
endmodule

// ----- rtl/core/wav_ctrl.sv -----
// parser controller: phase sequencing, handshake and result register
// depends on wav_pkg
module wav_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_first,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic             rsp_good,
   output wav_pkg::cmd_type cmd,
   input  wav_pkg::stat_type stat
);
   import wav_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        valid_ff, valid_in;
   status_type  st_ff, st_in;
   logic        good_ff, good_in;
   logic        acc;
   logic        emit;
   status_type  emit_st;

   assign req_ready = (phase_ff != PH_DIV) && (phase_ff != PH_OUT) && !valid_ff;
   assign acc = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      cmd = '0;
      emit = 1'b0;
      emit_st = ST_OK;
      good_in = good_ff;
      valid_in = valid_ff && !rsp_ready;
      st_in = st_ff;
      if (acc) begin
         if (req_first) begin
            cmd.clear = 1'b1;
            phase_in = PH_HDR;
         end else if (phase_ff != PH_IDLE) begin
            cmd.advance = 1'b1;
         end
         if (req_first || phase_ff != PH_IDLE) begin
            case (req_first ? PH_HDR : phase_ff)
               PH_HDR: begin
                  cmd.hdr_byte = 1'b1;
                  if (stat.sect_hdr_end && !req_first || stat.sect_hdr_end) begin
                     if (stat.magic_bad_now) begin
                        emit = 1'b1; emit_st = ST_BAD_MAGIC; phase_in = PH_IDLE;
                     end else begin
                        cmd.start_chunk = 1'b1; phase_in = PH_CHUNK;
                     end
                  end
               end
               PH_CHUNK: begin
                  cmd.chunk_byte = 1'b1;
                  if (stat.sect_chunk_end) begin
                     if (stat.is_fmt) begin
                        cmd.load_skip = 1'b1; phase_in = PH_FMT;
                     end else if (stat.is_data) begin
                        if (!stat.have_fmt) begin
                           emit = 1'b1; emit_st = ST_MISSING; phase_in = PH_IDLE;
                        end else if (stat.align_zero) begin
                           emit = 1'b1; emit_st = ST_ZERO_ALIGN; phase_in = PH_IDLE;
                        end else begin
                           cmd.div_start = 1'b1; phase_in = PH_DIV;
                        end
                     end else begin
                        cmd.load_skip = 1'b1;
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_FMT: begin
                  cmd.fmt_byte = 1'b1;
                  if (stat.sect_fmt_end) begin
                     if (!stat.tag_ok) begin
                        emit = 1'b1; emit_st = ST_BAD_TAG; phase_in = PH_IDLE;
                     end else begin
                        cmd.fmt_skip = 1'b1; phase_in = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  cmd.skip_byte = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
            // an entered skip of length zero goes straight to the next chunk header
            if (phase_in == PH_SKIP && stat.skip_zero_next) begin
               cmd.start_chunk = 1'b1; phase_in = PH_CHUNK;
            end
            if (req_last && !emit && phase_in != PH_IDLE && phase_in != PH_DIV) begin
               emit = 1'b1;
               emit_st = (phase_in == PH_HDR) ? ST_BAD_MAGIC : ST_MISSING;
               phase_in = PH_IDLE;
            end
         end
      end
      if (phase_ff == PH_DIV) begin
         if (stat.div_done) begin
            phase_in = PH_OUT;
         end else begin
            cmd.div_step = 1'b1;
         end
      end
      if (phase_ff == PH_OUT && !valid_ff) begin
         valid_in = 1'b1;
         st_in = stat.frames_zero ? ST_ZERO_FRAMES : ST_OK;
         good_in = !stat.frames_zero;
         phase_in = PH_IDLE;
      end
      if (emit) begin
         valid_in = 1'b1;
         st_in = emit_st;
         good_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         valid_ff <= 1'b0;
         st_ff <= ST_OK;
         good_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
         st_ff <= st_in;
         good_ff <= good_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = st_ff;
   assign rsp_good   = good_ff;
endmodule

// ----- rtl/core/wav_riff_header_parser.sv -----
// wav riff header parser: one byte per beat, one status beat per file
// an error result is registered in the cycle after its byte; at the data
// chunk a bit-serial divider first forms the frame count (32 steps)
// throughput: one byte per cycle, input held off during the divide and while a
// result waits; synchronous active-high reset clears control state and file_size
module wav_riff_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_block_align,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_data_offset,
   output logic [31:0] rsp_data_bytes,
   output logic [31:0] rsp_frame_count,
   output logic        rsp_playable
);
   import wav_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic        good;
   logic [15:0] ch, al, bits;
   logic [31:0] rate, offs, bytes, frames;
   logic        play;

   wav_datapath u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .data_byte(req_data_byte), .cmd, .stat,
      .o_channels(ch), .o_rate(rate), .o_align(al), .o_bits(bits),
      .o_offset(offs), .o_bytes(bytes), .o_frames(frames), .o_playable(play)
   );

   wav_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_first, .req_last,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_good(good), .cmd, .stat
   );

   // fields other than status read zero on an error beat
   assign rsp_channels        = good ? ch : 16'd0;
   assign rsp_sample_rate     = good ? rate : 32'd0;
   assign rsp_block_align     = good ? al : 16'd0;
   assign rsp_bits_per_sample = good ? bits : 16'd0;
   assign rsp_data_offset     = good ? offs : 32'd0;
   assign rsp_data_bytes      = good ? bytes : 32'd0;
   assign rsp_frame_count     = good ? frames : 32'd0;
   assign rsp_playable        = good & play;
endmodule
